/* rtl/core/ptp_pkg.sv */
// ----------------------------------------------------------------------------
// ptp_pkg: shared types for the PPPoE tag parser
// Result kinds, error codes and the result word that leaves the parse stage.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam logic [10:0] MaxPayloadReset = 11'd1494;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_VERSION   = 3'd1,
    ERR_TYPE      = 3'd2,
    ERR_LENGTH    = 3'd3,
    ERR_TAG_LEN   = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] tag_type;
    logic [10:0] tag_length;
    logic [7:0]  value_byte;
    logic [10:0] value_index;
    logic        tag_last;
    logic        packet_end;
    err_t        error_code;
  } result_t;

endpackage

/* rtl/core/pppoe_tag_parser.sv */
// ----------------------------------------------------------------------------
// pppoe_tag_parser: PPPoE discovery tag parser
// Walks the PPPoE header and the tag list one byte per cycle while in_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the frame on the in_* channel starting at the 6-byte PPPoE header,
//   one byte per word, with frame_last set on the last byte of the frame.
//   Results leave on the out_* channel: one word per tag value byte, one for
//   an empty tag, and one that accepts or rejects the packet unless a tag word
//   already closes it with packet_end. Bytes after the packet closes give
//   nothing until frame_last, which returns the parser to its start state; a
//   frame that ends with the packet open is rejected. A result is in the output
//   register the cycle after its byte is accepted. Bytes are taken one per cycle
//   while in_ready is high, via the single parse stage and output register.
//   When the receiver stalls with a result waiting, in_ready drops until the
//   result is taken; bytes that give no result still need the register free.
//   cfg_wr_en/cfg_wr_data write max_payload in the same edge; write it only
//   while the parser is idle.
//   Reset (rst, synchronous) clears the parse state and out_valid (not the
//   output data register) and sets max_payload to 1494.
// ----------------------------------------------------------------------------
module pppoe_tag_parser import ptp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] tag_type,
  output logic [10:0] tag_length,
  output logic [7:0]  value_byte,
  output logic [10:0] value_index,
  output logic        tag_last,
  output logic        packet_end,
  output logic [2:0]  error_code
);

  logic [10:0] max_payload;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     res_q;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  ptp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_last  (frame_last),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MaxPayloadReset;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // load only on a new result so a stalled word holds
  always_ff @(posedge clk) begin
    if (accept && res_valid) res_q <= res;
  end

  assign kind        = res_q.kind;
  assign tag_type    = res_q.tag_type;
  assign tag_length  = res_q.tag_length;
  assign value_byte  = res_q.value_byte;
  assign value_index = res_q.value_index;
  assign tag_last    = res_q.tag_last;
  assign packet_end  = res_q.packet_end;
  assign error_code  = res_q.error_code;

  a_reject_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REJECT) |-> packet_end && (error_code != ERR_NONE))
    else $error("reject word without packet_end or error code");

  a_value_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_VALUE || kind == KIND_EMPTY) |-> error_code == ERR_NONE)
    else $error("tag word carries an error code");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EMPTY) |-> tag_last && (value_index == 11'd0) &&
      (value_byte == 8'd0) && (tag_length == 11'd0))
    else $error("empty tag word malformed");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end && (kind == KIND_VALUE) |-> tag_last)
    else $error("packet closed in the middle of a tag value");

endmodule

/* rtl/core/ptp_parse.sv */
// ----------------------------------------------------------------------------
// ptp_parse: byte-wise PPPoE header and tag walker
// Holds the parse state and computes, for one accepted byte, the next state
// and at most one result word.
// ----------------------------------------------------------------------------
module ptp_parse import ptp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        frame_last,
  input  logic [10:0] max_payload,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TAGHDR = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [10:0] payload_length, payload_length_next;
  logic [11:0] payload_offset, payload_offset_next;
  logic [1:0]  tag_header_count, tag_header_count_next;
  logic [15:0] current_type, current_type_next;
  logic [15:0] current_length, current_length_next;
  logic [10:0] value_count, value_count_next;

  logic [15:0] hdr_len;
  logic [16:0] tag_end;
  logic        hit_end;

  function automatic result_t close_word(kind_t k, err_t e);
    result_t r;
    r            = '0;
    r.kind       = k;
    r.packet_end = 1'b1;
    r.error_code = e;
    return r;
  endfunction

  always_comb begin
    phase_next            = phase;
    header_count_next     = header_count;
    payload_length_next   = payload_length;
    payload_offset_next   = payload_offset;
    tag_header_count_next = tag_header_count;
    current_type_next     = current_type;
    current_length_next   = current_length;
    value_count_next      = value_count;
    res_valid             = 1'b0;
    res                   = '0;
    hdr_len               = {current_length[7:0], data_byte};
    tag_end               = '0;
    hit_end               = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        if (header_count == 3'd0) begin
          if (data_byte[7:4] != 4'd1) begin
            res = close_word(KIND_REJECT, ERR_VERSION);
            res_valid = 1'b1;
            phase_next = PH_DONE;
          end else if (data_byte[3:0] != 4'd1) begin
            res = close_word(KIND_REJECT, ERR_TYPE);
            res_valid = 1'b1;
            phase_next = PH_DONE;
          end
        end else if (header_count == 3'd4) begin
          current_length_next = {8'd0, data_byte};
        end else if (header_count == 3'd5) begin
          current_length_next = '0;
          if (hdr_len > {5'd0, max_payload}) begin
            res = close_word(KIND_REJECT, ERR_LENGTH);
            res_valid = 1'b1;
            phase_next = PH_DONE;
          end else if (hdr_len == 16'd0) begin
            res = close_word(KIND_ACCEPT, ERR_NONE);
            res_valid = 1'b1;
            phase_next = PH_DONE;
          end else begin
            payload_length_next   = hdr_len[10:0];
            payload_offset_next   = '0;
            tag_header_count_next = '0;
            phase_next            = PH_TAGHDR;
          end
        end
        header_count_next = header_count + 3'd1;
      end

      PH_TAGHDR: begin
        unique case (tag_header_count)
          2'd0: current_type_next   = {data_byte, 8'd0};
          2'd1: current_type_next   = {current_type[15:8], data_byte};
          2'd2: current_length_next = {data_byte, 8'd0};
          2'd3: current_length_next = {current_length[15:8], data_byte};
          default: current_type_next = current_type;
        endcase
        payload_offset_next   = payload_offset + 12'd1;
        tag_header_count_next = tag_header_count + 2'd1;
        tag_end = {5'd0, payload_offset_next} + {1'b0, current_length_next};
        hit_end = (payload_offset_next == {1'b0, payload_length});
        if (tag_header_count == 2'd3) begin
          if (current_type_next == 16'd0) begin
            // end-of-list tag closes the packet, its length is ignored
            res = close_word(KIND_ACCEPT, ERR_NONE);
            res_valid = 1'b1;
            phase_next = PH_DONE;
          end else if (tag_end > {6'd0, payload_length}) begin
            res = close_word(KIND_REJECT, ERR_TAG_LEN);
            res_valid = 1'b1;
            phase_next = PH_DONE;
          end else if (current_length_next == 16'd0) begin
            res.kind       = KIND_EMPTY;
            res.tag_type   = current_type_next;
            res.tag_last   = 1'b1;
            res.packet_end = hit_end;
            res_valid      = 1'b1;
            if (hit_end) phase_next = PH_DONE;
          end else begin
            value_count_next = '0;
            phase_next       = PH_VALUE;
          end
        end
      end

      PH_VALUE: begin
        payload_offset_next = payload_offset + 12'd1;
        value_count_next    = value_count + 11'd1;
        hit_end = (value_count_next == current_length[10:0]) &&
                  (payload_offset_next == {1'b0, payload_length});
        res.kind        = KIND_VALUE;
        res.tag_type    = current_type;
        res.tag_length  = current_length[10:0];
        res.value_byte  = data_byte;
        res.value_index = value_count;
        res.tag_last    = (value_count_next == current_length[10:0]);
        res.packet_end  = hit_end;
        res_valid       = 1'b1;
        if (res.tag_last) phase_next = hit_end ? PH_DONE : PH_TAGHDR;
      end

      PH_DONE: begin
        // drop bytes until the frame ends
      end

      default: phase_next = phase;
    endcase

    if (frame_last) begin
      if (phase_next != PH_DONE) begin
        res = close_word(KIND_REJECT, ERR_TRUNCATED);
        res_valid = 1'b1;
      end
      phase_next            = PH_HEADER;
      header_count_next     = '0;
      payload_length_next   = '0;
      payload_offset_next   = '0;
      tag_header_count_next = '0;
      current_type_next     = '0;
      current_length_next   = '0;
      value_count_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_count     <= '0;
      payload_length   <= '0;
      payload_offset   <= '0;
      tag_header_count <= '0;
      current_type     <= '0;
      current_length   <= '0;
      value_count      <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      header_count     <= header_count_next;
      payload_length   <= payload_length_next;
      payload_offset   <= payload_offset_next;
      tag_header_count <= tag_header_count_next;
      current_type     <= current_type_next;
      current_length   <= current_length_next;
      value_count      <= value_count_next;
    end
  end

endmodule
